// ===== sv/spt_pkg.sv =====
package spt_pkg;

    // Fixed field widths of the request and prefetch channels.
    localparam int PC_W     = 48;
    localparam int OUT_W    = 48;

    // Configuration port.
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int DEGREE_W = 4;

    // Register indexes (taken from the word address) and reset values.
    localparam logic REG_DEGREE = 1'b0;
    localparam logic [DEGREE_W-1:0] DEGREE_RESET = 4'd2;

endpackage

// ===== sv/stride_prefetch_table.sv =====
// Channel    | Direction | Handshake                  | Payload
// request    | in        | i_req_valid / o_req_ready  | i_load_pc, i_miss_addr
// prefetch   | out       | o_pf_valid / i_pf_ready    | o_prefetch_addr, o_last
// config     | in        | psel, penable, pwrite      | paddr, pwdata, prdata
//
// After reset a clearing pass walks every table entry; no request is taken then.
// A request passes through the table read, then the entry update written back.
// A confirmed stride then issues one prefetch address a cycle from a single adder while
// the output is not stalled, min(degree, MAX_DEGREE) addresses in all.
// One request is handled at a time; a new one is taken while the final address still waits.
// TABLE_ENTRIES must be a power of two.
module stride_prefetch_table #(
    parameter int TABLE_ENTRIES = 64,
    parameter int MAX_DEGREE    = 8,
    parameter int ADDR_BITS     = 48
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request channel
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  logic [spt_pkg::PC_W-1:0]    i_load_pc,
    input  logic [spt_pkg::PC_W-1:0]    i_miss_addr,
    // Prefetch channel
    output logic                        o_pf_valid,
    input  logic                        i_pf_ready,
    output logic [spt_pkg::OUT_W-1:0]   o_prefetch_addr,
    output logic                        o_last,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [spt_pkg::APB_AW-1:0]  paddr,
    input  logic [spt_pkg::APB_DW-1:0]  pwdata,
    output logic [spt_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    import spt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int TAG_W = PC_W - IDX_W;
    localparam int CNT_W = $clog2(MAX_DEGREE + 1);

    typedef struct packed {
        logic                 valid;
        logic [TAG_W-1:0]     tag;
        logic [ADDR_BITS-1:0] last_addr;
        logic [ADDR_BITS-1:0] stride;
        logic                 steady;
    } t_entry;

    localparam int WORD_W = $bits(t_entry);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [IDX_W-1:0]     r_clr_idx;
    logic [DEGREE_W-1:0]  r_degree;
    logic [IDX_W-1:0]     r_idx;
    logic [TAG_W-1:0]     r_tag;
    logic [ADDR_BITS-1:0] r_addr;
    logic [ADDR_BITS-1:0] r_pf;
    logic [ADDR_BITS-1:0] r_stride;
    logic [CNT_W-1:0]     r_left;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_addr;
    logic                 r_out_last;

    logic                 w_accept;
    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    t_entry               w_wentry;
    logic [WORD_W-1:0]    w_rdata;
    t_entry               w_rentry;
    logic                 w_hit;
    logic [ADDR_BITS-1:0] w_stride;
    logic                 w_repeat;
    logic [CNT_W-1:0]     w_count;
    logic                 w_fire;
    logic                 w_load;
    logic [ADDR_BITS-1:0] n_pf;

    assign w_accept = i_req_valid && o_req_ready;

    // Table memory.
    spt_table #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (WORD_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_re    (w_accept),
        .i_raddr (i_load_pc[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rentry = t_entry'(w_rdata);

    // Lookup and training of the entry read for the current request.
    assign w_hit    = w_rentry.valid && (w_rentry.tag == r_tag);
    assign w_stride = r_addr - w_rentry.last_addr;
    assign w_repeat = (w_stride == w_rentry.stride);

    // Prefetch count, saturated to the largest supported degree.
    always_comb begin
        if (int'(r_degree) > MAX_DEGREE) begin
            w_count = CNT_W'(MAX_DEGREE);
        end else begin
            w_count = CNT_W'(r_degree);
        end
    end

    assign w_fire = w_hit && w_rentry.steady && w_repeat && (w_count != '0);

    // Write-back word: a clearing pass writes empty entries, a lookup writes the update.
    always_comb begin
        w_we     = (r_state == S_CLEAR) || (r_state == S_LOOK);
        w_waddr  = (r_state == S_CLEAR) ? r_clr_idx : r_idx;
        w_wentry = '0;
        if (r_state == S_LOOK) begin
            w_wentry.valid     = 1'b1;
            w_wentry.tag       = r_tag;
            w_wentry.last_addr = r_addr;
            if (w_hit) begin
                w_wentry.stride = w_stride;
                w_wentry.steady = w_repeat;
            end
        end
    end

    // The output register takes a new address when it is empty or being drained.
    assign w_load = (r_state == S_EMIT) && (!r_out_valid || i_pf_ready);
    assign n_pf   = r_pf + r_stride;

    // Sequencer with the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_pf_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == IDX_W'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= w_fire ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out_valid <= 1'b1;
                        if (r_left == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request capture and prefetch address generation.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx  <= i_load_pc[IDX_W-1:0];
            r_tag  <= i_load_pc[PC_W-1:IDX_W];
            r_addr <= ADDR_BITS'(i_miss_addr);
        end
        if (r_state == S_LOOK) begin
            r_pf     <= r_addr;
            r_stride <= w_stride;
            r_left   <= w_count;
        end
        if (w_load) begin
            r_pf       <= n_pf;
            r_left     <= r_left - 1'b1;
            r_out_addr <= OUT_W'(n_pf);
            r_out_last <= (r_left == CNT_W'(1));
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEGREE_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_DEGREE)) begin
            r_degree <= pwdata[DEGREE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_DEGREE) ? APB_DW'(r_degree) : '0;
    assign pready = 1'b1;

    assign o_req_ready     = (r_state == S_IDLE);
    assign o_pf_valid      = r_out_valid;
    assign o_prefetch_addr = r_out_addr;
    assign o_last          = r_out_last;

`ifndef SYNTH
    // An accepted request always blocks the next cycle while its entry is updated.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_req_ready)
        else $error("request taken while the previous one was still being looked up");

    // The remaining count never runs out while addresses are still being issued.
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0))
        else $error("issue state entered with no prefetch left");

    // Loading the final address ends the burst.
    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_left == CNT_W'(1))) |=> ((r_state == S_IDLE) && o_pf_valid && o_last))
        else $error("burst did not end on its final address");

    // The table is never written while the block waits for a request.
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("table written outside a clearing pass or an update");
`endif

endmodule

// ===== sv/spt_table.sv =====
module spt_table #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 140
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Single read port, data registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    import spt_pkg::*;

    localparam int TABLE_ENTRIES  = 64;
    localparam int MAX_DEGREE     = 8;
    localparam int IDX_BITS       = $clog2(TABLE_ENTRIES);
    localparam int TAG_BITS       = PC_W - IDX_BITS;
    // Register index beyond the last implemented register.
    localparam int SPARE_REG      = 1;
    // Cycles for the block to finish a request that issues nothing.
    localparam int SETTLE_CYCLES  = 4 + 2 * MAX_DEGREE;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int STREAMS        = 8;

    typedef struct packed {
        logic [OUT_W-1:0] addr;
        logic             last;
    } prefetch_t;

    typedef struct {
        logic [PC_W-1:0] pc;
        logic [PC_W-1:0] next_addr;
        logic [PC_W-1:0] stride;
    } stream_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_req_valid;
    logic                o_req_ready;
    logic [PC_W-1:0]     i_load_pc;
    logic [PC_W-1:0]     i_miss_addr;
    logic                o_pf_valid;
    logic                i_pf_ready = 1'b0;
    logic [OUT_W-1:0]    o_prefetch_addr;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // Shadow copy of the prediction table and the degree register.
    logic                tbl_valid  [TABLE_ENTRIES];
    logic [TAG_BITS-1:0] tbl_tag    [TABLE_ENTRIES];
    logic [PC_W-1:0]     tbl_last   [TABLE_ENTRIES];
    logic [PC_W-1:0]     tbl_stride [TABLE_ENTRIES];
    logic                tbl_steady [TABLE_ENTRIES];
    logic [DEGREE_W-1:0] degree_reg;

    prefetch_t prefetch_expected[$];
    stream_t   streams[STREAMS];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    int        hold_left = 0;
    bit        no_idle = 1'b0;

    stride_prefetch_table uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_req_valid),
        .o_req_ready     (o_req_ready),
        .i_load_pc       (i_load_pc),
        .i_miss_addr     (i_miss_addr),
        .o_pf_valid      (o_pf_valid),
        .i_pf_ready      (i_pf_ready),
        .o_prefetch_addr (o_prefetch_addr),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [PC_W-1:0] random_addr();
        return PC_W'({$urandom(), $urandom()});
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i]  = 1'b0;
            tbl_tag[i]    = '0;
            tbl_last[i]   = '0;
            tbl_stride[i] = '0;
            tbl_steady[i] = 1'b0;
        end
        degree_reg = DEGREE_RESET;
    endfunction

    // Trains the table entry for one miss and queues the prefetches it causes.
    function automatic void train_and_predict(input logic [PC_W-1:0] pc,
                                              input logic [PC_W-1:0] addr);
        int unsigned         slot;
        logic [TAG_BITS-1:0] tag;
        logic [PC_W-1:0]     stride;
        logic [PC_W-1:0]     pf;
        logic                stride_match;
        int                  count;
        prefetch_t           item;
        slot = pc[IDX_BITS-1:0];
        tag  = pc[PC_W-1:IDX_BITS];
        if (!tbl_valid[slot] || tbl_tag[slot] != tag) begin
            tbl_valid[slot]  = 1'b1;
            tbl_tag[slot]    = tag;
            tbl_last[slot]   = addr;
            tbl_stride[slot] = '0;
            tbl_steady[slot] = 1'b0;
            return;
        end
        stride       = addr - tbl_last[slot];
        stride_match = (stride == tbl_stride[slot]);
        if (tbl_steady[slot] && stride_match) begin
            count = (degree_reg > MAX_DEGREE) ? MAX_DEGREE : degree_reg;
            pf    = addr;
            for (int k = 0; k < count; k++) begin
                pf        = pf + stride;
                item.addr = pf;
                item.last = (k == count - 1);
                prefetch_expected.push_back(item);
            end
        end
        tbl_steady[slot] = stride_match;
        tbl_stride[slot] = stride;
        tbl_last[slot]   = addr;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offers one miss request, sometimes after a random gap, and waits for it to be taken.
    task automatic send_miss(input logic [PC_W-1:0] pc, input logic [PC_W-1:0] addr);
        if (!no_idle && $urandom_range(99) < 32) begin
            i_req_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 32);
        end
        i_req_valid <= 1'b1;
        i_load_pc   <= pc;
        i_miss_addr <= addr;
        do @(posedge i_clk); while (!o_req_ready);
        train_and_predict(pc, addr);
    endtask

    // Drops the request valid and waits until every prefetch has come out.
    task automatic finish_requests();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (prefetch_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input int unsigned index, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(4 * index);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (index == REG_DEGREE) degree_reg = value[DEGREE_W-1:0];
        @(posedge i_clk);
    endtask

    // Reads the degree register back and compares it with the shadow copy.
    task automatic check_degree_reg();
        logic [APB_DW-1:0] value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_AW'(4 * REG_DEGREE);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (value !== APB_DW'(degree_reg))
            report_mismatch($sformatf("degree read %0h, expected %0h", value, degree_reg));
        @(posedge i_clk);
    endtask

    // Sends a run of misses from one pc with a constant stride.
    task automatic send_stride_run(input logic [PC_W-1:0] pc, input logic [PC_W-1:0] start,
                                   input logic [PC_W-1:0] stride, input int count);
        logic [PC_W-1:0] addr;
        addr = start;
        for (int i = 0; i < count; i++) begin
            send_miss(pc, addr);
            addr = addr + stride;
        end
    endtask

    // Degree at its reset value, then a stride that settles and issues prefetches.
    task automatic test_confirmed_stride();
        check_degree_reg();
        send_stride_run(48'h0000_1234_5678, 48'h0000_8000_0000, 48'd64, 5);
        finish_requests();
    endtask

    // All-ones pc with addresses wrapping past the top, and pc zero with addresses going below zero.
    task automatic test_address_wrap();
        send_stride_run({PC_W{1'b1}}, 48'hFFFF_FFFF_FF80, 48'h40, 4);
        send_stride_run('0, '0, -48'h1000, 4);
        finish_requests();
    endtask

    // The same address three times confirms a stride of zero.
    task automatic test_zero_stride();
        send_stride_run(48'h5555_AAAA_5555, 48'hAAAA_5555_AAAA, '0, 3);
        finish_requests();
    endtask

    // A second pc with the same index evicts the trained entry.
    task automatic test_pc_conflict();
        logic [PC_W-1:0] pc;
        pc = 48'h0000_0000_0ACE;
        send_stride_run(pc, 48'h1000, 48'h80, 3);
        send_miss(pc ^ (48'h1 << IDX_BITS), 48'h1180);
        send_stride_run(pc, 48'h1180, 48'h80, 2);
        finish_requests();
    endtask

    // A write beyond the last register must leave the degree alone.
    task automatic test_unused_register();
        reg_write(REG_DEGREE, 32'd5);
        reg_write(SPARE_REG, 32'hFFFF_FFF7);
        check_degree_reg();
        send_stride_run(48'h0F0F_0F0F_0F0F, 48'h2000_0000, -48'd192, 4);
        finish_requests();
    endtask

    // The receiver stalls for a long time while requests keep coming.
    task automatic test_output_backpressure();
        reg_write(REG_DEGREE, 32'd8);
        hold_left = 400;
        send_stride_run(48'h7777_0000_0013, 48'h3000_0000, 48'd256, 20);
        finish_requests();
    endtask

    function automatic logic [PC_W-1:0] pick_stride();
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return random_addr();
            3, 4, 5: return -PC_W'(64 * $urandom_range(1, 16));
            default: return PC_W'(64 * $urandom_range(1, 16));
        endcase
    endfunction

    // Mostly well-formed strided streams, plus stray misses and broken streams.
    task automatic test_random_traffic(input logic [APB_DW-1:0] degree, input int count);
        int              s;
        int              r;
        logic [PC_W-1:0] addr;
        reg_write(REG_DEGREE, degree);
        check_degree_reg();
        for (int k = 0; k < STREAMS; k++) begin
            streams[k].pc = random_addr();
            // The upper streams share an index with a lower one and fight over it.
            if (k >= STREAMS - 2)
                streams[k].pc[IDX_BITS-1:0] = streams[k - 2].pc[IDX_BITS-1:0];
            streams[k].next_addr = random_addr();
            streams[k].stride    = pick_stride();
        end
        for (int i = 0; i < count; i++) begin
            s = $urandom_range(STREAMS - 1);
            r = $urandom_range(99);
            if (r < 80) begin
                if ($urandom_range(19) == 0) streams[s].stride = pick_stride();
                addr = streams[s].next_addr;
                send_miss(streams[s].pc, addr);
                streams[s].next_addr = addr + streams[s].stride;
            end else if (r < 90) begin
                send_miss(random_addr(), random_addr());
            end else begin
                addr = random_addr();
                send_miss(streams[s].pc, addr);
                streams[s].next_addr = addr + streams[s].stride;
            end
        end
        finish_requests();
    endtask

    // Prefetch receiver: random stalls, or a long hold when a test asks for one.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_pf_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_pf_ready <= no_idle || ($urandom_range(99) >= 32);
        end
    end

    // Compares each prefetch with the oldest expected one.
    always @(posedge i_clk) begin
        prefetch_t want;
        if (i_rst_n && o_pf_valid && i_pf_ready) begin
            if (prefetch_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected prefetch %h", o_prefetch_addr));
            end else begin
                want = prefetch_expected.pop_front();
                if (o_prefetch_addr !== want.addr)
                    report_mismatch($sformatf("prefetch address %h, expected %h",
                                              o_prefetch_addr, want.addr));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last flag %b, expected %b at %h",
                                              o_last, want.last, want.addr));
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_pf_valid && i_pf_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_load_pc   = '0;
        i_miss_addr = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        clear_table();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_confirmed_stride();
        test_address_wrap();
        test_zero_stride();
        test_pc_conflict();
        test_unused_register();
        test_output_backpressure();
        test_random_traffic(32'd1, 70);
        no_idle = 1'b1;
        test_random_traffic(32'd8, 70);
        no_idle = 1'b0;
        test_random_traffic(32'd0, 70);
        test_random_traffic(32'hFFFF_FFFF, 70);
        test_random_traffic(32'd3, 70);
        test_random_traffic(APB_DW'($urandom_range(1, MAX_DEGREE)), 70);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/spt_pkg.sv
sv/spt_table.sv
sv/stride_prefetch_table.sv
bench/testbench.sv
